### design/q_learning_update_engine_assert.svh
// Assertion helpers for the Q-learning update engine checks.
`ifndef Q_LEARNING_UPDATE_ENGINE_ASSERT_SVH
`define Q_LEARNING_UPDATE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define QLUE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qlue check failed");

// Next-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define QLUE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qlue check failed");

`endif

### design/qlue_pkg.sv
package qlue_pkg;

    // field widths
    localparam int Q_W        = 20;
    localparam int CFG_W      = 16;
    localparam int STATE_IN_W = 7;
    localparam int ACT_IN_W   = 2;
    localparam int REWARD_W   = 16;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE    = 2'd2;

    localparam logic [CFG_W-1:0] LEARN_RATE_RST = 16'd6554;
    localparam logic [CFG_W-1:0] DISCOUNT_RST   = 16'd58982;
    localparam logic [CFG_W-1:0] EXPLORE_RST    = 16'd6554;

    // shared multiplier / accumulator
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 21;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 56;
    localparam int ACC_SHIFT = 16;
    localparam int QUOT_LSB  = 32;

    localparam logic [CFG_W:0] ALPHA_ONE = 17'd65536;

    typedef logic signed [Q_W-1:0] t_q;

    localparam t_q Q_MIN = 20'sh80000;
    localparam t_q Q_MAX = 20'sh7FFFF;

    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
        logic acc_shift;
    } t_mac_ctl;

endpackage

### design/qlue_row_ram.sv
module qlue_row_ram
    import qlue_pkg::*;
#(
    parameter int NUM_STATES  = 128,
    parameter int NUM_ACTIONS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(NUM_STATES)-1:0] i_waddr,
    input  t_q   [NUM_ACTIONS-1:0]        i_wdata,
    input  logic [$clog2(NUM_STATES)-1:0] i_raddr,
    output t_q   [NUM_ACTIONS-1:0]        o_rdata
);

    // one row of Q values per word
    t_q [NUM_ACTIONS-1:0] r_mem [NUM_STATES];
    t_q [NUM_ACTIONS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/qlue_mac.sv
module qlue_mac
    import qlue_pkg::*;
(
    input  logic                       i_clk,
    input  t_mac_ctl                   i_ctl,
    input  logic signed [MUL_A_W-1:0]  i_op_a,
    input  logic signed [MUL_B_W-1:0]  i_op_b,
    output logic signed [PROD_W-1:0]   o_prod,
    output logic signed [ACC_W-1:0]    o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] w_mult;
    logic signed [ACC_W-1:0]  w_ext;
    logic signed [ACC_W-1:0]  w_addend;

    assign w_mult   = i_op_a * i_op_b;
    assign w_ext    = ACC_W'(r_prod);
    assign w_addend = i_ctl.acc_shift ? (w_ext <<< ACC_SHIFT) : w_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_mult;
        end
        if (i_ctl.acc_load) begin
            r_acc <= w_addend;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + w_addend;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

### design/q_learning_update_engine.sv
// Channel   | Valid        | Stall        | Payload
// ----------+--------------+--------------+--------------------------------------------
// input     | i_in_valid   | o_in_stall   | i_cur_state, i_taken_action, i_reward_value,
//           |              |              | i_following_state, i_explore_draw,
//           |              |              | i_explore_action
// output    | o_out_valid  | i_out_stall  | o_updated_q, o_best_q_next, o_best_action_next,
//           |              |              | o_chosen_action_next
// config    | i_cfg_we     | -            | i_cfg_index, i_cfg_data
//
// A transfer in reads the following row, scans it for its maximum, makes four passes
// through the single 33x21 multiplier, writes the current row back and, unless the draw
// explores, scans the following row a second time; the comparator walks a row one entry
// a cycle and the row RAM has a registered read. No new transfer is taken until it is done.
// After reset a clearing pass writes a zero row to every state; o_in_stall is
// high throughout, config writes are still taken.
// A finished result waits in the output register, so the block takes the next item
// while the result is stalled; it holds in its last step only if that result is still stalled.
module q_learning_update_engine
    import qlue_pkg::*;
#(
    parameter int NUM_STATES  = 128,
    parameter int NUM_ACTIONS = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input transfer
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [STATE_IN_W-1:0]   i_cur_state,
    input  logic [ACT_IN_W-1:0]     i_taken_action,
    input  logic signed [REWARD_W-1:0] i_reward_value,
    input  logic [STATE_IN_W-1:0]   i_following_state,
    input  logic [CFG_W-1:0]        i_explore_draw,
    input  logic [ACT_IN_W-1:0]     i_explore_action,
    // result transfer
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_q                      o_updated_q,
    output t_q                      o_best_q_next,
    output logic [ACT_IN_W-1:0]     o_best_action_next,
    output logic [ACT_IN_W-1:0]     o_chosen_action_next,
    // configuration writes
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int SW          = $clog2(NUM_STATES);
    localparam int AW          = $clog2(NUM_ACTIONS);
    localparam int STATE_CODES = 2 ** STATE_IN_W;
    localparam int ACT_CODES   = 2 ** ACT_IN_W;
    localparam int NQ_W        = ACC_W - QUOT_LSB;

    localparam logic [SW-1:0] LAST_STATE = SW'(NUM_STATES - 1);
    localparam logic [AW-1:0] LAST_ACT   = AW'(NUM_ACTIONS - 1);
    localparam logic [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << (QUOT_LSB - 1);

    // sequencer codes
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_CLEAR   = 4'd0;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd1;
    localparam logic [ST_W-1:0] ST_RD_CUR  = 4'd2;
    localparam logic [ST_W-1:0] ST_SCAN    = 4'd3;
    localparam logic [ST_W-1:0] ST_MUL_AG  = 4'd4;
    localparam logic [ST_W-1:0] ST_MUL_AGM = 4'd5;
    localparam logic [ST_W-1:0] ST_MUL_Q   = 4'd6;
    localparam logic [ST_W-1:0] ST_MUL_R   = 4'd7;
    localparam logic [ST_W-1:0] ST_ACC     = 4'd8;
    localparam logic [ST_W-1:0] ST_WRITE   = 4'd9;
    localparam logic [ST_W-1:0] ST_FINISH  = 4'd10;

    // control registers
    logic [ST_W-1:0]  r_state, n_state;
    logic [AW-1:0]    r_k, n_k;
    logic             r_phase2, n_phase2;
    logic [SW-1:0]    r_clr_cnt, n_clr_cnt;
    logic             r_out_valid, n_out_valid;
    logic [CFG_W-1:0] r_learn_rate, r_discount, r_explore_thr;

    // item payload
    logic [SW-1:0]               r_s, r_ns;
    logic [AW-1:0]               r_a, r_xa;
    logic signed [REWARD_W-1:0]  r_reward;
    logic [CFG_W-1:0]            r_draw;
    t_q [NUM_ACTIONS-1:0]        r_row_n, r_row_c;
    t_q                          r_cmp_best, r_m;
    logic [AW-1:0]               r_cmp_idx, r_m_idx;

    // result register
    t_q                   r_out_q, r_out_best_q;
    logic [ACT_IN_W-1:0]  r_out_best_act, r_out_chosen;

    // index folding tables, built at elaboration
    logic [SW-1:0] w_state_lut [STATE_CODES];
    logic [AW-1:0] w_act_lut   [ACT_CODES];

    for (genvar gi = 0; gi < STATE_CODES; gi++) begin : g_state_lut
        localparam int SV = gi % NUM_STATES;
        assign w_state_lut[gi] = SW'(SV);
    end

    for (genvar gj = 0; gj < ACT_CODES; gj++) begin : g_act_lut
        localparam int AV = gj % NUM_ACTIONS;
        assign w_act_lut[gj] = AW'(AV);
    end

    // handshakes
    logic w_in_accept, w_out_free, w_explore;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_explore   = (r_draw < r_explore_thr);

    // row RAM
    logic                 w_we;
    logic [SW-1:0]        w_waddr, w_raddr;
    t_q [NUM_ACTIONS-1:0] w_wdata, w_row_wr, w_rdata;

    assign w_we    = (r_state == ST_CLEAR) || (r_state == ST_WRITE);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr_cnt : r_s;
    assign w_wdata = (r_state == ST_CLEAR) ? '0 : w_row_wr;
    // following row is fetched on the accepting edge, current row straight after
    assign w_raddr = (r_state == ST_IDLE) ? w_state_lut[i_following_state] : r_s;

    qlue_row_ram #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared comparator: one row entry per cycle, first entry taken outright,
    // strict greater-than keeps the lowest index on ties
    t_q   w_cand;
    logic w_take;

    assign w_cand = r_row_n[r_k];
    assign w_take = (r_k == '0) || (w_cand > r_cmp_best);

    // shared multiplier
    t_mac_ctl                   w_mac_ctl;
    logic signed [MUL_A_W-1:0]  w_op_a;
    logic signed [MUL_B_W-1:0]  w_op_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]    w_acc;
    logic [CFG_W:0]             w_one_minus;

    assign w_one_minus = ALPHA_ONE - {1'b0, r_learn_rate};

    // X = 2^16 * ((2^16 - A) * Q + A * r) + (A * G) * M
    always_comb begin
        w_mac_ctl = '0;
        w_op_a    = '0;
        w_op_b    = '0;
        unique case (r_state)
            ST_MUL_AG: begin
                w_mac_ctl.mul_en = 1'b1;
                w_op_a = $signed({{(MUL_A_W - CFG_W){1'b0}}, r_learn_rate});
                w_op_b = $signed({{(MUL_B_W - CFG_W){1'b0}}, r_discount});
            end
            ST_MUL_AGM: begin
                w_mac_ctl.mul_en = 1'b1;
                w_op_a = $signed({{(MUL_A_W - 2 * CFG_W){1'b0}}, w_prod[2*CFG_W-1:0]});
                w_op_b = MUL_B_W'(r_m);
            end
            ST_MUL_Q: begin
                w_mac_ctl.mul_en   = 1'b1;
                w_mac_ctl.acc_load = 1'b1;
                w_op_a = $signed({{(MUL_A_W - CFG_W - 1){1'b0}}, w_one_minus});
                w_op_b = MUL_B_W'(r_row_c[r_a]);
            end
            ST_MUL_R: begin
                w_mac_ctl.mul_en    = 1'b1;
                w_mac_ctl.acc_add   = 1'b1;
                w_mac_ctl.acc_shift = 1'b1;
                w_op_a = $signed({{(MUL_A_W - CFG_W){1'b0}}, r_learn_rate});
                w_op_b = MUL_B_W'(r_reward);
            end
            ST_ACC: begin
                w_mac_ctl.acc_add   = 1'b1;
                w_mac_ctl.acc_shift = 1'b1;
            end
            default: begin
            end
        endcase
    end

    qlue_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod),
        .o_acc  (w_acc)
    );

    // round half up, floor by 2^32, saturate to the Q range
    logic [ACC_W-1:0]        w_round;
    logic signed [NQ_W-1:0]  w_nq_wide;
    t_q                      w_nq;

    assign w_round   = w_acc + ACC_ROUND;
    assign w_nq_wide = $signed(w_round[ACC_W-1:QUOT_LSB]);

    always_comb begin
        priority if (w_nq_wide < NQ_W'(Q_MIN)) begin
            w_nq = Q_MIN;
        end else if (w_nq_wide > NQ_W'(Q_MAX)) begin
            w_nq = Q_MAX;
        end else begin
            w_nq = w_nq_wide[Q_W-1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_ACTIONS; j++) begin
            w_row_wr[j] = (AW'(j) == r_a) ? w_nq : r_row_c[j];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_phase2    = r_phase2;
        n_clr_cnt   = r_clr_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == LAST_STATE) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_RD_CUR;
                end
            end
            ST_RD_CUR: begin
                n_k      = '0;
                n_phase2 = 1'b0;
                n_state  = ST_SCAN;
            end
            ST_SCAN: begin
                n_k = r_k + 1'b1;
                if (r_k == LAST_ACT) begin
                    n_state = r_phase2 ? ST_FINISH : ST_MUL_AG;
                end
            end
            ST_MUL_AG:  n_state = ST_MUL_AGM;
            ST_MUL_AGM: n_state = ST_MUL_Q;
            ST_MUL_Q:   n_state = ST_MUL_R;
            ST_MUL_R:   n_state = ST_ACC;
            ST_ACC:     n_state = ST_WRITE;
            ST_WRITE: begin
                // greedy choice needs a fresh scan of the row as it stands now
                n_k      = '0;
                n_phase2 = 1'b1;
                n_state  = w_explore ? ST_FINISH : ST_SCAN;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_k           <= '0;
            r_phase2      <= 1'b0;
            r_clr_cnt     <= '0;
            r_out_valid   <= 1'b0;
            r_learn_rate  <= LEARN_RATE_RST;
            r_discount    <= DISCOUNT_RST;
            r_explore_thr <= EXPLORE_RST;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_phase2    <= n_phase2;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LEARN_RATE: r_learn_rate  <= i_cfg_data;
                    CFG_DISCOUNT:   r_discount    <= i_cfg_data;
                    CFG_EXPLORE:    r_explore_thr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s      <= w_state_lut[i_cur_state];
            r_a      <= w_act_lut[i_taken_action];
            r_ns     <= w_state_lut[i_following_state];
            r_reward <= i_reward_value;
            r_draw   <= i_explore_draw;
            r_xa     <= w_act_lut[i_explore_action];
        end
        if (r_state == ST_RD_CUR) begin
            r_row_n <= w_rdata;
        end
        if ((r_state == ST_SCAN) && !r_phase2) begin
            r_row_c <= w_rdata;
        end
        if ((r_state == ST_SCAN) && w_take) begin
            r_cmp_best <= w_cand;
            r_cmp_idx  <= r_k;
        end
        if (r_state == ST_MUL_AG) begin
            r_m     <= r_cmp_best;
            r_m_idx <= r_cmp_idx;
        end
        if ((r_state == ST_WRITE) && (r_s == r_ns)) begin
            r_row_n[r_a] <= w_nq;
        end
        // accumulator holds its sum until the next item, so the new value is
        // still on w_nq here and a waiting result is left untouched
        if ((r_state == ST_FINISH) && w_out_free) begin
            r_out_q        <= w_nq;
            r_out_best_q   <= r_m;
            r_out_best_act <= ACT_IN_W'(r_m_idx);
            r_out_chosen   <= w_explore ? ACT_IN_W'(r_xa) : ACT_IN_W'(r_cmp_idx);
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_updated_q          = r_out_q;
    assign o_best_q_next        = r_out_best_q;
    assign o_best_action_next   = r_out_best_act;
    assign o_chosen_action_next = r_out_chosen;

endmodule

### design/qlue_checker.sv
`include "q_learning_update_engine_assert.svh"

module qlue_checker
    import qlue_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_q   o_updated_q
);

    // a stalled result stays put
    `QLUE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_updated_q))

    // clearing pass keeps the input closed straight after reset
    `QLUE_ASSERT_IMPL(a_clear_busy, $past(!i_rst_n), o_in_stall)

    // an accepted item keeps the block busy in the following cycle
    `QLUE_ASSERT_NEXT(a_busy_after_take, i_in_valid && !o_in_stall, o_in_stall)

    // a new result only appears at the end of work
    `QLUE_ASSERT_IMPL(a_result_after_work, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind q_learning_update_engine qlue_checker u_qlue_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_updated_q (o_updated_q)
);

### sim/q_learning_update_engine_checker.sv
`timescale 1ns / 100ps

module q_learning_update_engine_checker
    import qlue_pkg::*;
#(
    parameter int NUM_STATES  = 128,
    parameter int NUM_ACTIONS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [STATE_IN_W-1:0]      i_cur_state,
    input  logic [ACT_IN_W-1:0]        i_taken_action,
    input  logic signed [REWARD_W-1:0] i_reward_value,
    input  logic [STATE_IN_W-1:0]      i_following_state,
    input  logic [CFG_W-1:0]           i_explore_draw,
    input  logic [ACT_IN_W-1:0]        i_explore_action,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  t_q                         i_updated_q,
    input  t_q                         i_best_q_next,
    input  logic [ACT_IN_W-1:0]        i_best_action_next,
    input  logic [ACT_IN_W-1:0]        i_chosen_action_next,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        t_q                  updated_q;
        t_q                  best_q_next;
        logic [ACT_IN_W-1:0] best_action_next;
        logic [ACT_IN_W-1:0] chosen_action_next;
    } t_q_update;

    localparam int     TABLE_DEPTH = NUM_STATES * NUM_ACTIONS;
    localparam int     RING_DEPTH  = 16;
    localparam longint ROUND_HALF  = 64'sh0000_0000_8000_0000;

    t_q               q_table [TABLE_DEPTH];
    logic [CFG_W-1:0] learn_rate;
    logic [CFG_W-1:0] discount;
    logic [CFG_W-1:0] explore_threshold;
    t_q_update        expected_ring [RING_DEPTH];
    int               ring_head;
    int               ring_tail;
    int               fail_count;

    // row maximum, ties to the lowest action
    function automatic void scan_row(input int unsigned row, output t_q peak,
                                     output logic [ACT_IN_W-1:0] peak_action);
        int unsigned base;
        base        = row * NUM_ACTIONS;
        peak        = q_table[base];
        peak_action = '0;
        for (int unsigned k = 1; k < NUM_ACTIONS; k++) begin
            if (q_table[base + k] > peak) begin
                peak        = q_table[base + k];
                peak_action = ACT_IN_W'(k);
            end
        end
    endfunction

    function automatic t_q_update predict_update(
        input logic [STATE_IN_W-1:0]      cur,
        input logic [ACT_IN_W-1:0]        act,
        input logic signed [REWARD_W-1:0] reward,
        input logic [STATE_IN_W-1:0]      nxt,
        input logic [CFG_W-1:0]           draw,
        input logic [ACT_IN_W-1:0]        xact
    );
        t_q_update           res;
        int unsigned         entry;
        int unsigned         next_row;
        t_q                  peak;
        logic [ACT_IN_W-1:0] peak_action;
        t_q                  peak_after;
        logic [ACT_IN_W-1:0] greedy_after;
        t_q                  old_q;
        longint              blend;
        longint              rounded;

        next_row = nxt % NUM_STATES;
        scan_row(next_row, peak, peak_action);

        entry = (cur % NUM_STATES) * NUM_ACTIONS + (act % NUM_ACTIONS);
        old_q = q_table[entry];
        // everything in units of 2^-32 of a Q step before the final rounding
        blend = longint'(32'd65536 - learn_rate) * longint'(old_q) * 64'sd65536
              + longint'(learn_rate) * (longint'(reward) * 64'sd65536
                                        + longint'(discount) * longint'(peak));
        rounded = (blend + ROUND_HALF) >>> 32;
        if (rounded > longint'(Q_MAX))
            rounded = longint'(Q_MAX);
        if (rounded < longint'(Q_MIN))
            rounded = longint'(Q_MIN);
        q_table[entry] = t_q'(rounded);

        res.updated_q        = t_q'(rounded);
        res.best_q_next      = peak;
        res.best_action_next = peak_action;
        if (draw < explore_threshold) begin
            res.chosen_action_next = ACT_IN_W'(xact % NUM_ACTIONS);
        end else begin
            // greedy pick sees the row after the write
            scan_row(next_row, peak_after, greedy_after);
            res.chosen_action_next = greedy_after;
        end
        return res;
    endfunction

    function automatic void check_field(input string field, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_q_update want;
        t_q_update fresh;
        if (!i_rst_n) begin
            foreach (q_table[e])
                q_table[e] = '0;
            learn_rate        = LEARN_RATE_RST;
            discount          = DISCOUNT_RST;
            explore_threshold = EXPLORE_RST;
            ring_head  = 0;
            ring_tail  = 0;
            fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (ring_tail == ring_head) begin
                    $error("result transfer with no update outstanding");
                    fail_count++;
                end else begin
                    want = expected_ring[ring_head % RING_DEPTH];
                    ring_head++;
                    check_field("updated_q", want.updated_q, i_updated_q);
                    check_field("best_q_next", want.best_q_next, i_best_q_next);
                    check_field("best_action_next", want.best_action_next,
                                i_best_action_next);
                    check_field("chosen_action_next", want.chosen_action_next,
                                i_chosen_action_next);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fresh = predict_update(i_cur_state, i_taken_action, i_reward_value,
                                       i_following_state, i_explore_draw, i_explore_action);
                if (ring_tail - ring_head == RING_DEPTH) begin
                    $error("too many updates outstanding");
                    fail_count++;
                end else begin
                    expected_ring[ring_tail % RING_DEPTH] = fresh;
                    ring_tail++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEARN_RATE: learn_rate        = i_cfg_data;
                    CFG_DISCOUNT:   discount          = i_cfg_data;
                    CFG_EXPLORE:    explore_threshold = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    = ring_tail - ring_head;
        o_fail_count = fail_count;
    end

endmodule

### sim/q_learning_update_engine_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the Q-learning update engine. Prediction and
// comparison live in the checker, which watches every port from the side.
module q_learning_update_engine_tb;
    import qlue_pkg::*;

    localparam int NUM_STATES      = 128;
    localparam int NUM_ACTIONS     = 4;
    localparam int RESET_CYCLES    = 7;
    // covers the worst-case step, with a little margin on top
    localparam int SETTLE_CYCLES   = 2 * NUM_ACTIONS + 16;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int HOLDOFF_PHASE   = 2;
    localparam int QUIET_PHASE     = 4;
    localparam int RANDOM_PHASE    = 3;
    // index 3 decodes to no register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                       i_clk;
    logic                       i_rst_n            = 1'b0;
    logic                       i_in_valid         = 1'b0;
    logic                       o_in_stall;
    logic [STATE_IN_W-1:0]      i_cur_state        = '0;
    logic [ACT_IN_W-1:0]        i_taken_action     = '0;
    logic signed [REWARD_W-1:0] i_reward_value     = '0;
    logic [STATE_IN_W-1:0]      i_following_state  = '0;
    logic [CFG_W-1:0]           i_explore_draw     = '0;
    logic [ACT_IN_W-1:0]        i_explore_action   = '0;
    logic                       o_out_valid;
    logic                       i_out_stall        = 1'b0;
    t_q                         o_updated_q;
    t_q                         o_best_q_next;
    logic [ACT_IN_W-1:0]        o_best_action_next;
    logic [ACT_IN_W-1:0]        o_chosen_action_next;
    logic                       i_cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index        = '0;
    logic [CFG_W-1:0]           i_cfg_data         = '0;

    int fail_count;
    int pending;

    // idling controls shared between the sender and the result sink
    bit tx_quiet       = 1'b0;
    bit rx_quiet       = 1'b0;
    int holdoff_asks   = 0;
    int holdoff_served = 0;
    int holdoff_left   = 0;

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    q_learning_update_engine #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_cur_state          (i_cur_state),
        .i_taken_action       (i_taken_action),
        .i_reward_value       (i_reward_value),
        .i_following_state    (i_following_state),
        .i_explore_draw       (i_explore_draw),
        .i_explore_action     (i_explore_action),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_updated_q          (o_updated_q),
        .o_best_q_next        (o_best_q_next),
        .o_best_action_next   (o_best_action_next),
        .o_chosen_action_next (o_chosen_action_next),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    q_learning_update_engine_checker #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) q_update_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_cur_state          (i_cur_state),
        .i_taken_action       (i_taken_action),
        .i_reward_value       (i_reward_value),
        .i_following_state    (i_following_state),
        .i_explore_draw       (i_explore_draw),
        .i_explore_action     (i_explore_action),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_updated_q          (o_updated_q),
        .i_best_q_next        (o_best_q_next),
        .i_best_action_next   (o_best_action_next),
        .i_chosen_action_next (o_chosen_action_next),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    // Result sink. Normally stalls at random, with a chance of 7 in 100; a hold-off request
    // from the stimulus makes it refuse results for a long counted stretch so
    // that the output register fills and the block stalls its input.
    always @(negedge i_clk) begin : result_sink
        if (holdoff_left != 0) begin
            i_out_stall  <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_served != holdoff_asks) begin
            holdoff_served <= holdoff_asks;
            holdoff_left   <= HOLDOFF_CYCLES;
            i_out_stall    <= 1'b1;
        end else begin
            i_out_stall <= !rx_quiet && ($urandom_range(99) < 7);
        end
    end

    // One register write; the caller lowers the write enable after a group,
    // so back-to-back writes never pulse it low and high in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] alpha, input logic [CFG_W-1:0] gam,
                                  input logic [CFG_W-1:0] eps);
        write_reg(CFG_LEARN_RATE, alpha);
        write_reg(CFG_DISCOUNT, gam);
        write_reg(CFG_EXPLORE, eps);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one transition and hold it until the transfer happens. Idle gaps
    // are decided up front so valid gets a single assignment per step.
    task automatic send_transition(
        input logic [STATE_IN_W-1:0]      cur,
        input logic [ACT_IN_W-1:0]        act,
        input logic signed [REWARD_W-1:0] rwd,
        input logic [STATE_IN_W-1:0]      nxt,
        input logic [CFG_W-1:0]           draw,
        input logic [ACT_IN_W-1:0]        xact
    );
        int gap;
        gap = 0;
        while (!tx_quiet && $urandom_range(99) < 7)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_cur_state       <= cur;
        i_taken_action    <= act;
        i_reward_value    <= rwd;
        i_following_state <= nxt;
        i_explore_draw    <= draw;
        i_explore_action  <= xact;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Let every outstanding update come back, then give the block its step
    // latency so it is truly idle before registers are touched.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly episode-like walks through a small pool of states, so rows get
    // revisited and values build up (and saturate with alpha and gamma near
    // one); rewards lean one way for long runs. The rest is pure noise.
    task automatic run_random_phase(input int n_items, input int base, input int span);
        logic [STATE_IN_W-1:0] cur;
        logic [STATE_IN_W-1:0] nxt;
        logic [STATE_IN_W-1:0] walk;
        logic [REWARD_W-1:0]   rwd;
        bit                    negative;
        walk     = STATE_IN_W'(base);
        negative = 1'b0;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(29) == 0)
                    walk = STATE_IN_W'(base + $urandom_range(span - 1));
                if ($urandom_range(59) == 0)
                    negative = !negative;
                cur = walk;
                nxt = STATE_IN_W'(base + $urandom_range(span - 1));
                case ($urandom_range(3))
                    0:       rwd = negative ? 16'h8000 : 16'h7FFF;
                    1:       rwd = {negative, 15'($urandom)};
                    default: rwd = 16'($urandom);
                endcase
                walk = nxt;
                send_transition(cur, ACT_IN_W'($urandom), rwd, nxt, 16'($urandom),
                                ACT_IN_W'($urandom));
            end else begin
                send_transition(STATE_IN_W'($urandom), ACT_IN_W'($urandom), 16'($urandom),
                                STATE_IN_W'($urandom), 16'($urandom), ACT_IN_W'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] alpha;
        logic [CFG_W-1:0] gam;
        logic [CFG_W-1:0] eps;
        int               span;
        int               base;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Written during the clearing pass: the spare index must leave every
        // register at its reset value, which the first directed items rely on.
        write_reg(CFG_SPARE, 16'hFFFF);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);

        // Directed, reset settings (alpha ~0.1, gamma ~0.9, epsilon ~0.1)
        send_transition(7'd0, 2'd0, 16'h7FFF, 7'd127, 16'hFFFF, 2'd3);   // zero row: tie to action 0
        send_transition(7'd0, 2'd1, 16'h7FFF, 7'd0, 16'hFFFF, 2'd0);     // row read and written
        send_transition(7'd0, 2'd2, 16'h8000, 7'd0, 16'd6553, 2'd2);     // draw just under epsilon
        send_transition(7'd0, 2'd3, 16'h0000, 7'd0, 16'd6554, 2'd1);     // draw equal: greedy
        send_transition(7'd127, 2'd3, 16'h8000, 7'd127, 16'h0000, 2'd3);
        send_transition(7'd127, 2'd0, 16'h0001, 7'd0, 16'h5555, 2'd1);
        // build a row that is negative throughout, then read it from elsewhere
        send_transition(7'd126, 2'd0, 16'h8000, 7'd126, 16'hFFFF, 2'd0);
        send_transition(7'd126, 2'd1, 16'h8000, 7'd126, 16'hFFFF, 2'd1);
        send_transition(7'd126, 2'd2, 16'h8000, 7'd126, 16'hFFFF, 2'd2);
        send_transition(7'd126, 2'd3, 16'h8000, 7'd126, 16'hFFFF, 2'd3);
        send_transition(7'd85, 2'd2, 16'h5555, 7'd126, 16'hAAAA, 2'd2);
        send_transition(7'd42, 2'd1, 16'hAAAA, 7'd42, 16'h8000, 2'd0);
        drain();

        // zero threshold never explores, even with a zero draw
        apply_settings(16'hFFFF, 16'hFFFF, 16'h0000);
        send_transition(7'd1, 2'd0, 16'h7FFF, 7'd0, 16'h0000, 2'd3);
        send_transition(7'd126, 2'd3, 16'h8000, 7'd0, 16'h0000, 2'd2);
        send_transition(7'd0, 2'd1, 16'h7FFF, 7'd0, 16'h0000, 2'd1);
        drain();

        // alpha zero keeps Q; epsilon at full scale explores below 65535 only
        apply_settings(16'h0000, 16'h0000, 16'hFFFF);
        send_transition(7'd0, 2'd0, 16'h7FFF, 7'd0, 16'hFFFE, 2'd1);
        send_transition(7'd0, 2'd1, 16'h8000, 7'd127, 16'hFFFF, 2'd2);
        send_transition(7'd127, 2'd2, 16'h1234, 7'd127, 16'h0000, 2'd0);
        drain();

        // Random phases, each under its own settings
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin alpha = 16'hFFFF; gam = 16'hFFFF; eps = 16'h0000; span = 2;  end
                1:       begin alpha = 16'h0000; gam = 16'h0000; eps = 16'hFFFF; span = 6;  end
                2:       begin alpha = 16'h8000; gam = 16'hE666; eps = 16'h4000; span = 4;  end
                RANDOM_PHASE: begin
                    alpha = 16'($urandom);
                    gam   = 16'($urandom);
                    eps   = 16'($urandom);
                    span  = 8;
                end
                4:       begin alpha = 16'h0001; gam = 16'hFFFF; eps = 16'hFFFF; span = 3;  end
                5:       begin alpha = 16'hFFFF; gam = 16'h0000; eps = 16'h0000; span = 6;  end
                default: begin alpha = 16'h199A; gam = 16'hE666; eps = 16'h199A; span = 16; end
            endcase
            apply_settings(alpha, gam, eps);
            tx_quiet <= (p == QUIET_PHASE);
            rx_quiet <= (p == QUIET_PHASE);
            if (p == HOLDOFF_PHASE)
                holdoff_asks <= holdoff_asks + 1;
            base = $urandom_range(NUM_STATES - span);
            run_random_phase(ITEMS_PER_PHASE, base, span);
            drain();
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin : watchdog
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### q_learning_update_engine.f
+incdir+design
design/qlue_pkg.sv
design/qlue_row_ram.sv
design/qlue_mac.sv
design/q_learning_update_engine.sv
design/qlue_checker.sv
sim/q_learning_update_engine_checker.sv
sim/q_learning_update_engine_tb.sv
